>>> design/mcg128_pkg.sv
// Shared types, constants and step tables for the 128-bit MCG with double conversion.
// No dependencies.
`timescale 1ns / 1ps

package mcg128_pkg;

    localparam logic [63:0] MULT_HI = 64'h0fc94e3bf4e9ab32;
    localparam logic [63:0] MULT_LO = 64'h866458cd56f5e605;
    localparam logic [127:0] MULT = {MULT_HI, MULT_LO};
    localparam int unsigned EXP_BIAS = 1023;
    localparam int unsigned FRAC_BITS = 52;
    localparam int unsigned SIGN_EXP_BITS = 12;
    localparam int unsigned MAC_STEPS = 10;
    localparam int unsigned NORM_STEPS = 6;
    localparam int unsigned FMUL_STEPS = 4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED,
        OP_START,
        OP_MAC,
        OP_COMMIT,
        OP_NORM,
        OP_PREP,
        OP_RND,
        OP_SCALE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       fmul;     // multiplier fed from float mantissas
        logic [1:0] a_idx;    // 32-bit limb of operand a
        logic [1:0] b_idx;    // 32-bit limb of operand b
        logic [1:0] sh;       // product weight, in 32-bit limbs
        logic [2:0] norm_k;   // normalize step
    } t_cmd;

    typedef struct packed {
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic [1:0] sh;
    } t_pair;

    // Limb pairs of the 128x128 product that land below bit 128.
    function automatic t_pair mac_pair(input logic [3:0] step);
        t_pair p;
        case (step)
            4'd0: p = '{2'd0, 2'd0, 2'd0};
            4'd1: p = '{2'd0, 2'd1, 2'd1};
            4'd2: p = '{2'd1, 2'd0, 2'd1};
            4'd3: p = '{2'd0, 2'd2, 2'd2};
            4'd4: p = '{2'd1, 2'd1, 2'd2};
            4'd5: p = '{2'd2, 2'd0, 2'd2};
            4'd6: p = '{2'd0, 2'd3, 2'd3};
            4'd7: p = '{2'd1, 2'd2, 2'd3};
            4'd8: p = '{2'd2, 2'd1, 2'd3};
            4'd9: p = '{2'd3, 2'd0, 2'd3};
            default: p = '{2'd0, 2'd0, 2'd0};
        endcase
        return p;
    endfunction

    // Limb pairs of the 53x53 mantissa product.
    function automatic t_pair fmul_pair(input logic [1:0] step);
        t_pair p;
        case (step)
            2'd0: p = '{2'd0, 2'd0, 2'd0};
            2'd1: p = '{2'd0, 2'd1, 2'd1};
            2'd2: p = '{2'd1, 2'd0, 2'd1};
            2'd3: p = '{2'd1, 2'd1, 2'd2};
            default: p = '{2'd0, 2'd0, 2'd0};
        endcase
        return p;
    endfunction

endpackage

>>> design/mcg128_if.sv
// Valid/ready channel interfaces for the MCG input and result beats.
// No dependencies.
`timescale 1ns / 1ps

interface mcg128_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] seed_low;
    logic [63:0] seed_high;
    logic [63:0] bound;

    modport source (output valid, action, seed_low, seed_high, bound, input ready);
    modport sink   (input valid, action, seed_low, seed_high, bound, output ready);
endinterface

interface mcg128_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_value;
    logic [63:0] unit_double_bits;
    logic [63:0] scaled_value;

    modport source (output valid, raw_value, unit_double_bits, scaled_value, input ready);
    modport sink   (input valid, raw_value, unit_double_bits, scaled_value, output ready);
endinterface

>>> design/mcg128_random_with_double_convert.sv
// Top level of the 128-bit MCG with double conversion: ties the sequencer
// to the datapath. Depends on mcg128_pkg, mcg128_if, mcg128_ctrl, mcg128_dp.
`timescale 1ns / 1ps
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------
//  i_in    | in  | action, seed_low, seed_high, bound
//  o_out   | out | raw_value, unit_double_bits, scaled_value
//
// A seed load gives its zero result in the cycle after accept; a draw uses
// the single shared 32x32 multiplier (ten limb products for the state update,
// four for the mantissa product) and the six-step normalizer.
// Reset (i_rst_n low, synchronous) loads state 1, as after seeding zero.
// One item is in flight at a time; i_in.ready is high only when idle and the
// result register is free or being emptied. A stalled result holds its beat.

module mcg128_random_with_double_convert (
    input logic         i_clk,
    input logic         i_rst_n,
    mcg128_in_if.sink   i_in,
    mcg128_out_if.source o_out
);
    import mcg128_pkg::*;

    t_cmd w_cmd;

    // sequencer: states, step counter, handshakes
    mcg128_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // datapath: holds the generator state and the result register
    mcg128_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_seed_low         (i_in.seed_low),
        .i_seed_high        (i_in.seed_high),
        .i_bound            (i_in.bound),
        .o_raw_value        (o_out.raw_value),
        .o_unit_double_bits (o_out.unit_double_bits),
        .o_scaled_value     (o_out.scaled_value)
    );

endmodule

>>> design/mcg128_ctrl.sv
// Sequencer for the MCG: issues datapath commands and owns the handshakes.
// Depends on mcg128_pkg.
`timescale 1ns / 1ps

module mcg128_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output mcg128_pkg::t_cmd o_cmd
);
    import mcg128_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_COMMIT, S_NORM, S_PREP, S_FMUL, S_RND, S_SCALE
    } t_state;

    t_state     r_state;
    logic [3:0] r_step;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_accept;
    t_pair      w_pair;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd  = '{op: OP_NONE, fmul: 1'b0, a_idx: 2'd0, b_idx: 2'd0, sh: 2'd0, norm_k: 3'd0};
        w_pair = mac_pair(r_step);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = i_in_action ? OP_START : OP_SEED;
                end
            end
            S_MAC: begin
                o_cmd.op    = OP_MAC;
                o_cmd.a_idx = w_pair.a_idx;
                o_cmd.b_idx = w_pair.b_idx;
                o_cmd.sh    = w_pair.sh;
            end
            S_COMMIT: o_cmd.op = OP_COMMIT;
            S_NORM: begin
                o_cmd.op     = OP_NORM;
                o_cmd.norm_k = r_step[2:0];
            end
            S_PREP: o_cmd.op = OP_PREP;
            S_FMUL: begin
                w_pair      = fmul_pair(r_step[1:0]);
                o_cmd.op    = OP_MAC;
                o_cmd.fmul  = 1'b1;
                o_cmd.a_idx = w_pair.a_idx;
                o_cmd.b_idx = w_pair.b_idx;
                o_cmd.sh    = w_pair.sh;
            end
            S_RND: o_cmd.op = OP_RND;
            S_SCALE: begin
                if (w_out_free) begin
                    o_cmd.op = OP_SCALE;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // raise on a seed load or a finished draw, drop once taken
            if ((r_state == S_IDLE && w_accept && !i_in_action) ||
                (r_state == S_SCALE && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_step <= 4'd0;
                    if (w_accept && i_in_action) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(MAC_STEPS - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_step  <= 4'd0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(NORM_STEPS - 1)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_step  <= 4'd0;
                    r_state <= S_FMUL;
                end
                S_FMUL: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(FMUL_STEPS - 1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: r_state <= S_SCALE;
                S_SCALE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/mcg128_dp.sv
// Datapath of the MCG: state, shared 32x32 multiply-accumulate, normalizer,
// rounding and scaling. Depends on mcg128_pkg.
`timescale 1ns / 1ps

module mcg128_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcg128_pkg::t_cmd i_cmd,
    input  logic [63:0]      i_seed_low,
    input  logic [63:0]      i_seed_high,
    input  logic [63:0]      i_bound,
    output logic [63:0]      o_raw_value,
    output logic [63:0]      o_unit_double_bits,
    output logic [63:0]      o_scaled_value
);
    import mcg128_pkg::*;

    logic [127:0] r_state;
    logic [127:0] r_acc;
    logic [63:0]  r_bound;
    logic [63:0]  r_rn, r_bn;
    logic [5:0]   r_lzr, r_lzb;
    logic         r_rzero, r_bzero;
    logic [52:0]  r_mb, r_mu;
    logic signed [8:0] r_eadj, r_e;
    logic [53:0]  r_r;
    logic [63:0]  r_raw, r_unit;
    logic [63:0]  r_raw_o, r_unit_o, r_scaled_o;

    logic [31:0]  w_a, w_b;
    logic [63:0]  w_prod;
    logic [127:0] w_acc_n;
    logic [63:0]  n_rn, n_bn;
    logic [5:0]   n_lzr, n_lzb;
    logic [53:0]  w_bsum;
    logic [52:0]  w_mant;
    logic         w_inc;
    logic         w_rinc;
    logic [53:0]  w_rsum;
    logic [71:0]  w_wide;
    logic [8:0]   w_neg;
    logic [63:0]  w_scaled;

    // shared 32x32 multiplier, accumulated at a limb offset
    always_comb begin
        if (i_cmd.fmul) begin
            w_a = i_cmd.a_idx[0] ? {11'd0, r_mb[52:32]} : r_mb[31:0];
            w_b = i_cmd.b_idx[0] ? {11'd0, r_mu[52:32]} : r_mu[31:0];
        end else begin
            w_a = r_state[32*i_cmd.a_idx +: 32];
            w_b = MULT[32*i_cmd.b_idx +: 32];
        end
        w_prod  = {32'd0, w_a} * {32'd0, w_b};
        w_acc_n = r_acc + ({64'd0, w_prod} << {i_cmd.sh, 5'd0});
    end

    // one binary-search step of the leading-zero normalize, both lanes
    always_comb begin
        n_rn = r_rn; n_lzr = r_lzr;
        n_bn = r_bn; n_lzb = r_lzb;
        case (i_cmd.norm_k)
            3'd0: begin
                if (r_rn[63:32] == '0) begin n_rn = r_rn << 32; n_lzr = r_lzr + 6'd32; end
                if (r_bn[63:32] == '0) begin n_bn = r_bn << 32; n_lzb = r_lzb + 6'd32; end
            end
            3'd1: begin
                if (r_rn[63:48] == '0) begin n_rn = r_rn << 16; n_lzr = r_lzr + 6'd16; end
                if (r_bn[63:48] == '0) begin n_bn = r_bn << 16; n_lzb = r_lzb + 6'd16; end
            end
            3'd2: begin
                if (r_rn[63:56] == '0) begin n_rn = r_rn << 8; n_lzr = r_lzr + 6'd8; end
                if (r_bn[63:56] == '0) begin n_bn = r_bn << 8; n_lzb = r_lzb + 6'd8; end
            end
            3'd3: begin
                if (r_rn[63:60] == '0) begin n_rn = r_rn << 4; n_lzr = r_lzr + 6'd4; end
                if (r_bn[63:60] == '0) begin n_bn = r_bn << 4; n_lzb = r_lzb + 6'd4; end
            end
            3'd4: begin
                if (r_rn[63:62] == '0) begin n_rn = r_rn << 2; n_lzr = r_lzr + 6'd2; end
                if (r_bn[63:62] == '0) begin n_bn = r_bn << 2; n_lzb = r_lzb + 6'd2; end
            end
            3'd5: begin
                if (!r_rn[63]) begin n_rn = r_rn << 1; n_lzr = r_lzr + 6'd1; end
                if (!r_bn[63]) begin n_bn = r_bn << 1; n_lzb = r_lzb + 6'd1; end
            end
            default: begin
                n_rn = r_rn; n_bn = r_bn;
            end
        endcase
    end

    // bound to 53-bit mantissa, round to nearest even
    always_comb begin
        w_mant = r_bn[63:11];
        w_inc  = r_bn[10] && ((|r_bn[9:0]) || r_bn[11]);
        w_bsum = {1'b0, w_mant} + {53'd0, w_inc};
    end

    // product rounding
    always_comb begin
        if (r_acc[105]) begin
            w_rinc = r_acc[52] && ((|r_acc[51:0]) || r_acc[53]);
            w_rsum = {1'b0, r_acc[105:53]} + {53'd0, w_rinc};
        end else begin
            w_rinc = r_acc[51] && ((|r_acc[50:0]) || r_acc[52]);
            w_rsum = {1'b0, r_acc[104:52]} + {53'd0, w_rinc};
        end
    end

    // truncate toward zero at exponent r_e, saturate at 2^64-1
    always_comb begin
        w_neg    = 9'(-r_e);
        w_wide   = {18'd0, r_r} << r_e[3:0];
        w_scaled = '0;
        if (r_rzero || r_bzero) begin
            w_scaled = '0;
        end else if (!r_e[8]) begin
            if (r_e > 9'sd13 || (|w_wide[71:64])) begin
                w_scaled = '1;
            end else begin
                w_scaled = w_wide[63:0];
            end
        end else if (w_neg < 9'd64) begin
            w_scaled = {10'd0, r_r} >> w_neg[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 128'd1;
        end else begin
            case (i_cmd.op)
                OP_SEED: begin
                    r_state    <= {i_seed_high[62:0], i_seed_low, 1'b1};
                    r_raw_o    <= '0;
                    r_unit_o   <= '0;
                    r_scaled_o <= '0;
                end
                OP_START: begin
                    r_acc   <= '0;
                    r_bound <= i_bound;
                end
                OP_MAC: r_acc <= w_acc_n;
                OP_COMMIT: begin
                    r_state <= r_acc;
                    r_raw   <= r_acc[127:64];
                    r_rn    <= r_acc[127:64];
                    r_bn    <= r_bound;
                    r_lzr   <= '0;
                    r_lzb   <= '0;
                    r_rzero <= (r_acc[127:64] == '0);
                    r_bzero <= (r_bound == '0);
                end
                OP_NORM: begin
                    r_rn  <= n_rn;
                    r_bn  <= n_bn;
                    r_lzr <= n_lzr;
                    r_lzb <= n_lzb;
                end
                OP_PREP: begin
                    r_mu   <= {1'b1, r_rn[62:11]};
                    r_unit <= r_rzero ? 64'd0
                            : {1'b0, 11'(11'(EXP_BIAS - 1) - {5'd0, r_lzr}), r_rn[62:11]};
                    r_mb   <= w_bsum[53] ? w_bsum[53:1] : w_bsum[52:0];
                    r_eadj <= 9'sd10 - $signed({3'd0, r_lzb}) - $signed({3'd0, r_lzr})
                            + $signed({8'd0, w_bsum[53]});
                    r_acc  <= '0;
                end
                OP_RND: begin
                    r_r <= w_rsum;
                    r_e <= r_eadj + $signed({8'd0, r_acc[105]});
                end
                OP_SCALE: begin
                    r_raw_o    <= r_raw;
                    r_unit_o   <= r_unit;
                    r_scaled_o <= w_scaled;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_raw_value        = r_raw_o;
    assign o_unit_double_bits = r_unit_o;
    assign o_scaled_value     = r_scaled_o;

endmodule

>>> design/mcg128_chk.sv
// Port-level checks for the MCG top level, attached by bind.
// Depends on mcg128_if through the bound top level.
`timescale 1ns / 1ps

module mcg128_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_raw,
    input logic [63:0] i_unit,
    input logic [63:0] i_scaled
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_raw)
            && $stable(i_unit) && $stable(i_scaled))
        else $error("result beat changed while stalled");

    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_action |=> i_out_valid && i_raw == 64'd0
            && i_unit == 64'd0 && i_scaled == 64'd0)
        else $error("seed load gave no zero result");

    a_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_unit == 64'd0) == (i_raw == 64'd0)) && !i_unit[63])
        else $error("unit value does not track raw value");

    a_scaled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_raw == 64'd0 |-> i_scaled == 64'd0)
        else $error("scaled value nonzero for zero draw");

endmodule

bind mcg128_random_with_double_convert mcg128_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_raw       (o_out.raw_value),
    .i_unit      (o_out.unit_double_bits),
    .i_scaled    (o_out.scaled_value)
);

>>> dv/mcg128_tb_if.sv
// Testbench view of the MCG channels: reuses the design interfaces.
// Depends on design/mcg128_if.sv; holds no logic of its own.
`timescale 1ns / 1ps

// The design's mcg128_in_if and mcg128_out_if are used directly by tb.
// This file keeps the interface slot of the dv folder and declares nothing.

>>> dv/tb.sv
// Self-checking bench for the 128-bit MCG with double conversion: seeds,
// draws and scaled draws are predicted in-bench and checked per beat.
// Depends on mcg128_pkg, mcg128_if and mcg128_random_with_double_convert.
`timescale 1ns / 1ps

class mcg_scoreboard;
    logic [127:0] gen_state;
    logic [191:0] expected_beats[$];
    int           errors;

    function new();
        gen_state = 128'd1;
        errors = 0;
    endfunction

    // Truncated [0,1) encoding of the upper half: normalize on the leading one.
    function logic [63:0] unit_of(input logic [63:0] raw);
        int lz;
        int sh;
        logic [63:0] frac;
        lz = 0;
        if (raw == 64'd0) return 64'd0;
        while (raw[63 - lz] == 1'b0) lz++;
        sh = lz + 1;
        frac = (sh >= 64) ? 64'd0 : ((raw << sh) >> mcg128_pkg::SIGN_EXP_BITS);
        return frac | (64'(mcg128_pkg::EXP_BIAS - sh) << mcg128_pkg::FRAC_BITS);
    endfunction

    function logic [63:0] scaled_of(input logic [63:0] bound, input logic [63:0] ubits);
        real bd;
        real prod;
        longint q;
        bd = real'(bound[63:32]) * 4294967296.0 + real'(bound[31:0]);
        prod = bd * $bitstoreal(ubits);
        if (!(prod > 0.0)) return 64'd0;
        if (prod >= 18446744073709551616.0) return '1;
        // Split the conversion so values above 2^63 stay exact.
        if (prod >= 9223372036854775808.0)
            return {1'b1, 63'(longint'(prod - 9223372036854775808.0))};
        // The cast rounds; step back to truncate toward zero.
        q = longint'(prod);
        if (real'(q) > prod) q = q - 1;
        return 64'(q);
    endfunction

    function void note_input(input logic act, input logic [63:0] slo,
                             input logic [63:0] shi, input logic [63:0] bound);
        logic [63:0] raw;
        logic [63:0] ub;
        if (act == 1'b0) begin
            gen_state = {shi, slo} << 1 | 128'd1;
            expected_beats.push_back('0);
        end else begin
            gen_state = gen_state * mcg128_pkg::MULT;
            raw = gen_state[127:64];
            ub = unit_of(raw);
            expected_beats.push_back({raw, ub, scaled_of(bound, ub)});
        end
    endfunction

    function void check_result(input logic [63:0] raw, input logic [63:0] ub,
                               input logic [63:0] sc);
        logic [191:0] exp_beat;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat raw=%h", $time, raw);
            errors++;
            return;
        end
        exp_beat = expected_beats.pop_front();
        if (raw !== exp_beat[191:128]) begin
            $display("%0t: raw exp %h got %h", $time, exp_beat[191:128], raw);
            errors++;
        end
        if (ub !== exp_beat[127:64]) begin
            $display("%0t: unit exp %h got %h", $time, exp_beat[127:64], ub);
            errors++;
        end
        if (sc !== exp_beat[63:0]) begin
            $display("%0t: scaled exp %h got %h", $time, exp_beat[63:0], sc);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   idle_cycles;

    mcg128_in_if  in_ch();
    mcg128_out_if out_ch();
    mcg_scoreboard sb;

    mcg128_random_with_double_convert u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold one beat on the input channel until the block takes it.
    task automatic send_beat(input logic act, input logic [63:0] slo,
                             input logic [63:0] shi, input logic [63:0] bound);
        int gap;
        gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.seed_low  <= slo;
        in_ch.seed_high <= shi;
        in_ch.bound     <= bound;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(act, slo, shi, bound);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Bounds with a bias toward the extremes so rounding of large bounds is hit.
    function automatic logic [63:0] pick_bound();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return 64'(1) << $urandom_range(0, 63);
            2: return 64'($urandom_range(0, 1000));
            default: return rand64();
        endcase
    endfunction

    // Sample results at the rising edge; the ready is changed at falling edges.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) < 10) ? 1'b0 : (gap_len() == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.raw_value, out_ch.unit_double_bits, out_ch.scaled_value);
    end

    // Watchdog: count cycles where neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        idle_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.seed_low = '0;
        in_ch.seed_high = '0;
        in_ch.bound = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Draw from the reset state, then hit the seed and bound extremes.
        send_beat(1'b1, '0, '0, '1);
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b0, '1, '1, '1);
        send_beat(1'b1, '0, '0, '1);
        send_beat(1'b0, '0, '0, '0);
        send_beat(1'b1, '1, '1, 64'd1);
        send_beat(1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
        send_beat(1'b1, '0, '0, 64'h8000_0000_0000_0000);
        send_beat(1'b1, '0, '0, 64'h0020_0000_0000_0001);
        send_beat(1'b1, '0, '0, 64'hffff_ffff_ffff_fc00);
        send_beat(1'b1, '0, '0, 64'hffff_ffff_ffff_fbff);
        send_beat(1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '0);
        send_beat(1'b1, '0, '0, '1);

        // Random part: mostly draws, with occasional reseeds.
        repeat (1200) begin
            if ($urandom_range(0, 99) < 12)
                send_beat(1'b0, rand64(), rand64(), rand64());
            else
                send_beat(1'b1, rand64(), rand64(), pick_bound());
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> mcg128_random_with_double_convert.f
design/mcg128_pkg.sv
design/mcg128_if.sv
design/mcg128_ctrl.sv
design/mcg128_dp.sv
design/mcg128_random_with_double_convert.sv
design/mcg128_chk.sv
dv/mcg128_tb_if.sv
dv/tb.sv
